// File: hdl/pmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmp_pkg
// Shared types and constants for the piece message parser.
// ----------------------------------------------------------------------------
package pmp_pkg;

   localparam logic [7:0]  PIECE_ID      = 8'd7;
   localparam logic [31:0] HDR_OVERHEAD  = 32'd9;
   localparam logic [15:0] MAX_LEN_RESET = 16'd32768;

   localparam int          CSR_AW        = 3;
   localparam logic        CSR_IDX_MAX_LEN = 1'b0;

   localparam logic [1:0] KIND_HEADER   = 2'd0;
   localparam logic [1:0] KIND_BLOCK    = 2'd1;
   localparam logic [1:0] KIND_LEFTOVER = 2'd2;
   localparam logic [1:0] KIND_DISCARD  = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEN,
      PH_ID,
      PH_INDEX,
      PH_OFFSET,
      PH_DATA,
      PH_DONE,
      PH_FAIL
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_piece;
      logic       payload_end;
      logic       id_match;
   } item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  byte_kind;
      logic [31:0] piece_index;
      logic [31:0] block_offset;
      logic [15:0] block_length;
      logic        piece_valid;
      logic        piece_complete;
   } result_type;

endpackage
`default_nettype wire

// File: hdl/pmp_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmp_req_if
// Input channel: one payload byte per word with start and end marks.
// ----------------------------------------------------------------------------
interface pmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_piece;
   logic       payload_end;

   modport source (output valid, data_byte, new_piece, payload_end, input ready);
   modport sink   (input valid, data_byte, new_piece, payload_end, output ready);
endinterface
`default_nettype wire

// File: hdl/pmp_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmp_rsp_if
// Result channel: classified byte with the current piece header state.
// ----------------------------------------------------------------------------
interface pmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  byte_kind;
   logic [31:0] piece_index;
   logic [31:0] block_offset;
   logic [15:0] block_length;
   logic        piece_valid;
   logic        piece_complete;

   modport source (output valid, out_byte, byte_kind, piece_index, block_offset,
                   block_length, piece_valid, piece_complete, input ready);
   modport sink   (input valid, out_byte, byte_kind, piece_index, block_offset,
                   block_length, piece_valid, piece_complete, output ready);
endinterface
`default_nettype wire

// File: hdl/pmp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmp_front
// Input stage: register each word and pre-classify the id byte.
// ----------------------------------------------------------------------------
module pmp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   pmp_req_if.sink               req,
   output pmp_pkg::item_type     push_item,
   output logic                  push_valid,
   input  wire logic             push_ready
);

   logic               valid_ff, valid_in;
   pmp_pkg::item_type  item_ff, item_in;
   logic               take;

   assign req.ready = !valid_ff || push_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in              = 1'b1;
         item_in.data_byte     = req.data_byte;
         item_in.new_piece     = req.new_piece;
         item_in.payload_end   = req.payload_end;
         item_in.id_match      = (req.data_byte == pmp_pkg::PIECE_ID);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_item  = item_ff;
   assign push_valid = valid_ff;

endmodule
`default_nettype wire

// File: hdl/pmp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmp_queue
// Two-entry queue between the input stage and the parser.
// ----------------------------------------------------------------------------
module pmp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pmp_pkg::item_type  push_item,
   input  wire logic               push_valid,
   output logic                    push_ready,
   output pmp_pkg::item_type       pop_item,
   output logic                    pop_valid,
   input  wire logic               pop_ready
);

   pmp_pkg::item_type  entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule
`default_nettype wire

// File: hdl/pmp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmp_back
// Parser: track header phase, gather fields, classify and emit each word.
// ----------------------------------------------------------------------------
module pmp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [15:0]        max_block_length,
   input  wire pmp_pkg::item_type  pop_item,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   pmp_rsp_if.source               rsp
);

   pmp_pkg::phase_type phase_ff, phase_in, ph, ph_mid;
   logic [1:0]         cnt_ff, cnt_in, cnt_eff;
   logic [31:0]        acc_ff, acc_in, acc_eff, gathered;
   logic               ka_ff, ka_in, ka_eff;
   logic [31:0]        idx_ff, idx_in, idx_eff;
   logic [31:0]        off_ff, off_in, off_eff;
   logic [15:0]        exp_ff, exp_in, exp_eff;
   logic [15:0]        rc_ff, rc_in, rc_eff, rc_plus;
   logic               valid_ff, valid_in, valid_eff;
   logic               cmpl_ff, cmpl_in, cmpl_eff;
   logic               first_ff, first_in, first_eff;
   logic               out_valid_ff, out_valid_in;
   pmp_pkg::result_type out_ff, out_in;
   logic               take, start, done, skip, bad_len;
   logic [31:0]        len_minus;
   logic [1:0]         kind;

   assign pop_ready = !out_valid_ff || rsp.ready;
   assign take      = pop_valid && pop_ready;
   assign start     = pop_valid && pop_item.new_piece;

   always_comb begin
      ph        = start ? pmp_pkg::PH_LEN : phase_ff;
      cnt_eff   = start ? 2'd0 : cnt_ff;
      acc_eff   = start ? 32'd0 : acc_ff;
      ka_eff    = start ? 1'b0 : ka_ff;
      idx_eff   = start ? 32'd0 : idx_ff;
      off_eff   = start ? 32'd0 : off_ff;
      exp_eff   = start ? 16'd0 : exp_ff;
      rc_eff    = start ? 16'd0 : rc_ff;
      valid_eff = start ? 1'b1 : valid_ff;
      cmpl_eff  = start ? 1'b0 : cmpl_ff;
      first_eff = start ? 1'b1 : first_ff;
      gathered  = {acc_eff[23:0], pop_item.data_byte};
      done      = (cnt_eff == 2'd3);
      len_minus = gathered - pmp_pkg::HDR_OVERHEAD;
      skip      = (gathered == 32'd0) && !ka_eff;
      bad_len   = (gathered < pmp_pkg::HDR_OVERHEAD) ||
                  (len_minus > {16'd0, max_block_length});
      rc_plus   = rc_eff + 16'd1;
   end

   // next phase
   always_comb begin
      ph_mid = ph;
      unique case (ph)
         pmp_pkg::PH_LEN: begin
            if (done) begin
               if (skip) ph_mid = pmp_pkg::PH_LEN;
               else if (bad_len) ph_mid = pmp_pkg::PH_FAIL;
               else ph_mid = pmp_pkg::PH_ID;
            end
         end
         pmp_pkg::PH_ID: begin
            ph_mid = pop_item.id_match ? pmp_pkg::PH_INDEX : pmp_pkg::PH_FAIL;
         end
         pmp_pkg::PH_INDEX: begin
            if (done) ph_mid = pmp_pkg::PH_OFFSET;
         end
         pmp_pkg::PH_OFFSET: begin
            if (done) ph_mid = (exp_eff == 16'd0) ? pmp_pkg::PH_DONE : pmp_pkg::PH_DATA;
         end
         pmp_pkg::PH_DATA: begin
            if (rc_plus == exp_eff) ph_mid = pmp_pkg::PH_DONE;
         end
         pmp_pkg::PH_DONE: begin
            if (first_eff) ph_mid = pmp_pkg::PH_FAIL;
         end
         pmp_pkg::PH_IDLE, pmp_pkg::PH_FAIL: begin
            ph_mid = ph;
         end
      endcase
      phase_in = ph_mid;
      if (pop_item.payload_end && (ph_mid inside {pmp_pkg::PH_LEN, pmp_pkg::PH_ID,
                                                  pmp_pkg::PH_INDEX,
                                                  pmp_pkg::PH_OFFSET})) begin
         phase_in = pmp_pkg::PH_FAIL;
      end
   end

   // datapath and flags
   always_comb begin
      cnt_in   = cnt_eff;
      acc_in   = acc_eff;
      ka_in    = ka_eff;
      idx_in   = idx_eff;
      off_in   = off_eff;
      exp_in   = exp_eff;
      rc_in    = rc_eff;
      kind     = pmp_pkg::KIND_DISCARD;
      unique case (ph)
         pmp_pkg::PH_LEN, pmp_pkg::PH_INDEX, pmp_pkg::PH_OFFSET: begin
            kind   = pmp_pkg::KIND_HEADER;
            cnt_in = done ? 2'd0 : cnt_eff + 2'd1;
            acc_in = done ? 32'd0 : gathered;
            if (done && ph == pmp_pkg::PH_LEN) begin
               if (skip) ka_in = 1'b1;
               else if (!bad_len) exp_in = len_minus[15:0];
            end
            if (done && ph == pmp_pkg::PH_INDEX) idx_in = gathered;
            if (done && ph == pmp_pkg::PH_OFFSET) off_in = gathered;
         end
         pmp_pkg::PH_ID: begin
            kind = pmp_pkg::KIND_HEADER;
         end
         pmp_pkg::PH_DATA: begin
            kind  = pmp_pkg::KIND_BLOCK;
            rc_in = rc_plus;
         end
         pmp_pkg::PH_DONE: begin
            kind = first_eff ? pmp_pkg::KIND_DISCARD : pmp_pkg::KIND_LEFTOVER;
         end
         pmp_pkg::PH_IDLE, pmp_pkg::PH_FAIL: begin
            kind = pmp_pkg::KIND_DISCARD;
         end
      endcase
      valid_in = (phase_in == pmp_pkg::PH_FAIL) ? 1'b0 : valid_eff;
      cmpl_in  = (phase_in == pmp_pkg::PH_FAIL) || (phase_in == pmp_pkg::PH_DONE) ||
                 cmpl_eff;
      first_in = pop_item.payload_end ? 1'b0 : first_eff;

      out_in.out_byte       = pop_item.data_byte;
      out_in.byte_kind      = kind;
      out_in.piece_index    = idx_in;
      out_in.block_offset   = off_in;
      out_in.block_length   = exp_in;
      out_in.piece_valid    = valid_in;
      out_in.piece_complete = cmpl_in;
      out_valid_in = take ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pmp_pkg::PH_IDLE;
         cnt_ff       <= 2'd0;
         acc_ff       <= 32'd0;
         ka_ff        <= 1'b0;
         idx_ff       <= 32'd0;
         off_ff       <= 32'd0;
         exp_ff       <= 16'd0;
         rc_ff        <= 16'd0;
         valid_ff     <= 1'b0;
         cmpl_ff      <= 1'b0;
         first_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            acc_ff   <= acc_in;
            ka_ff    <= ka_in;
            idx_ff   <= idx_in;
            off_ff   <= off_in;
            exp_ff   <= exp_in;
            rc_ff    <= rc_in;
            valid_ff <= valid_in;
            cmpl_ff  <= cmpl_in;
            first_ff <= first_in;
         end
      end
      if (take) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.out_byte       = out_ff.out_byte;
   assign rsp.byte_kind      = out_ff.byte_kind;
   assign rsp.piece_index    = out_ff.piece_index;
   assign rsp.block_offset   = out_ff.block_offset;
   assign rsp.block_length   = out_ff.block_length;
   assign rsp.piece_valid    = out_ff.piece_valid;
   assign rsp.piece_complete = out_ff.piece_complete;

   a_fail_flags: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pmp_pkg::PH_FAIL |-> !valid_ff && cmpl_ff)
      else $error("failed piece with wrong flags");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pmp_pkg::PH_DATA |-> rc_ff < exp_ff)
      else $error("block count past expected length");

   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid_ff)
      else $error("taken word not presented");

endmodule
`default_nettype wire

// File: hdl/piece_message_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piece_message_parser
// Piece message header parser with byte classification and pass-through.
// A word passes the input register, a queue entry and the output register.
// Throughput: one word per cycle while rsp is ready; parser updates per word.
// Input stage, two-entry queue and output register let each side stall alone.
// Reset (synchronous): parser idle, all piece state zero, limit 32768.
// ----------------------------------------------------------------------------
module piece_message_parser (
   input  wire logic                       clock,
   input  wire logic                       reset,
   pmp_req_if.sink                         req_port,
   pmp_rsp_if.source                       rsp_port,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [pmp_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [15:0]        max_len_ff, max_len_in;
   pmp_pkg::item_type  push_item, pop_item;
   logic               push_valid, push_ready, pop_valid, pop_ready;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == pmp_pkg::CSR_IDX_MAX_LEN);
   assign max_len_in = csr_wr ? csr_pwdata[15:0] : max_len_ff;
   assign csr_prdata = (csr_paddr[2] == pmp_pkg::CSR_IDX_MAX_LEN) ?
                       {16'd0, max_len_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= pmp_pkg::MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   pmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   pmp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   pmp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .max_block_length (max_len_ff),
      .pop_item         (pop_item),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .rsp              (rsp_port)
   );

endmodule
`default_nettype wire

// File: tb/piece_message_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piece_message_parser_test
// Self-checking bench for the piece message parser. A short table of
// handcrafted words covers keep-alive, zero-length blocks, leftover, short
// payload and bad id. Random piece messages follow under several block
// length limits. Each byte is checked against the table or a local model.
// ----------------------------------------------------------------------------
module piece_message_parser_test;

   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_WORDS  = 70;
   localparam int PHASE_COUNT  = 5;

   typedef struct {
      logic [7:0]  data_byte;
      logic        new_piece;
      logic        payload_end;
      logic        typed;
      logic [1:0]  kind;
      logic [31:0] index;
      logic [31:0] offset;
      logic [15:0] blen;
      logic        valid;
      logic        complete;
   } stim_word_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [pmp_pkg::CSR_AW-1:0]   csr_paddr;
   logic [31:0]                  csr_pwdata;
   logic [31:0]                  csr_prdata;
   logic                         csr_pready;

   pmp_req_if req_if ();
   pmp_rsp_if rsp_if ();

   piece_message_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_if),
      .rsp_port    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // parser model state
   pmp_pkg::phase_type ph;
   logic [1:0]  hdr_cnt;
   logic [31:0] field_acc;
   logic        keepalive_seen;
   logic [31:0] cur_index;
   logic [31:0] cur_offset;
   logic [15:0] cur_blen;
   logic [15:0] data_cnt;
   logic        cur_valid;
   logic        cur_complete;
   logic        in_first_payload;
   logic [15:0] max_blen;

   pmp_pkg::result_type classified_due [$];
   stim_word_type       stim_words [$];
   int          fail_count;
   int          words_in;
   int          words_out;
   int          pieces_opened;
   int          kind_count [4];
   bit          src_burst;
   bit          sink_burst;
   logic [15:0] limit_plan [PHASE_COUNT];

   stim_word_type opening_words [26] = '{
      '{8'hFF, '0, '0, '1, pmp_pkg::KIND_DISCARD, '0, '0, '0, '0, '0},
      '{8'h00, '1, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h09, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h07, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'hFF, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'hFF, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'hFF, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'hFF, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '1, '1, pmp_pkg::KIND_HEADER, '1, '0, '0, '1, '1},
      '{8'h5A, '0, '1, '1, pmp_pkg::KIND_LEFTOVER, '1, '0, '0, '1, '1},
      '{8'hFF, '1, '1, '1, pmp_pkg::KIND_HEADER, '0, '0, '0, '0, '1},
      '{8'h81, '0, '0, '1, pmp_pkg::KIND_DISCARD, '0, '0, '0, '0, '1},
      '{8'h00, '1, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h00, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h0A, '0, '0, '0, '0, '0, '0, '0, '0, '0},
      '{8'h06, '0, '0, '1, pmp_pkg::KIND_HEADER, '0, '0, 16'd1, '0, '1}
   };

   always #5 clock = ~clock;

   function automatic void clear_parser();
      max_blen         = pmp_pkg::MAX_LEN_RESET;
      ph               = pmp_pkg::PH_IDLE;
      hdr_cnt          = '0;
      field_acc        = '0;
      keepalive_seen   = 1'b0;
      cur_index        = '0;
      cur_offset       = '0;
      cur_blen         = '0;
      data_cnt         = '0;
      cur_valid        = 1'b0;
      cur_complete     = 1'b0;
      in_first_payload = 1'b0;
   endfunction

   function automatic void drop_piece();
      cur_valid    = 1'b0;
      cur_complete = 1'b1;
      ph           = pmp_pkg::PH_FAIL;
   endfunction

   // shift one header byte in; true once four bytes are gathered
   function automatic bit shift_in(logic [7:0] b);
      field_acc = {field_acc[23:0], b};
      if (hdr_cnt == 2'd3) begin
         hdr_cnt = '0;
         return 1'b1;
      end
      hdr_cnt = hdr_cnt + 2'd1;
      return 1'b0;
   endfunction

   function automatic pmp_pkg::result_type classify_byte(logic [7:0] b, logic start,
                                                         logic last);
      logic [1:0]          kind;
      logic [31:0]         len;
      pmp_pkg::result_type r;
      kind = pmp_pkg::KIND_DISCARD;
      if (start) begin
         ph               = pmp_pkg::PH_LEN;
         hdr_cnt          = '0;
         field_acc        = '0;
         keepalive_seen   = 1'b0;
         cur_index        = '0;
         cur_offset       = '0;
         cur_blen         = '0;
         data_cnt         = '0;
         cur_valid        = 1'b1;
         cur_complete     = 1'b0;
         in_first_payload = 1'b1;
      end
      case (ph)
         pmp_pkg::PH_LEN: begin
            kind = pmp_pkg::KIND_HEADER;
            if (shift_in(b)) begin
               len       = field_acc;
               field_acc = '0;
               if (len == 32'd0 && !keepalive_seen) begin
                  keepalive_seen = 1'b1;
               end else if (len < pmp_pkg::HDR_OVERHEAD ||
                            len - pmp_pkg::HDR_OVERHEAD > {16'd0, max_blen}) begin
                  drop_piece();
               end else begin
                  cur_blen = 16'(len - pmp_pkg::HDR_OVERHEAD);
                  ph       = pmp_pkg::PH_ID;
               end
            end
         end
         pmp_pkg::PH_ID: begin
            kind = pmp_pkg::KIND_HEADER;
            if (b != pmp_pkg::PIECE_ID) drop_piece();
            else ph = pmp_pkg::PH_INDEX;
         end
         pmp_pkg::PH_INDEX: begin
            kind = pmp_pkg::KIND_HEADER;
            if (shift_in(b)) begin
               cur_index = field_acc;
               field_acc = '0;
               ph        = pmp_pkg::PH_OFFSET;
            end
         end
         pmp_pkg::PH_OFFSET: begin
            kind = pmp_pkg::KIND_HEADER;
            if (shift_in(b)) begin
               cur_offset = field_acc;
               field_acc  = '0;
               if (cur_blen == 16'd0) begin
                  cur_complete = 1'b1;
                  ph           = pmp_pkg::PH_DONE;
               end else begin
                  ph = pmp_pkg::PH_DATA;
               end
            end
         end
         pmp_pkg::PH_DATA: begin
            kind     = pmp_pkg::KIND_BLOCK;
            data_cnt = data_cnt + 16'd1;
            if (data_cnt == cur_blen) begin
               cur_complete = 1'b1;
               ph           = pmp_pkg::PH_DONE;
            end
         end
         pmp_pkg::PH_DONE: begin
            if (in_first_payload) begin
               kind = pmp_pkg::KIND_DISCARD;
               drop_piece();
            end else begin
               kind = pmp_pkg::KIND_LEFTOVER;
            end
         end
         default: kind = pmp_pkg::KIND_DISCARD;
      endcase
      if (last) begin
         if (ph >= pmp_pkg::PH_LEN && ph <= pmp_pkg::PH_OFFSET) drop_piece();
         in_first_payload = 1'b0;
      end
      r.out_byte       = b;
      r.byte_kind      = kind;
      r.piece_index    = cur_index;
      r.block_offset   = cur_offset;
      r.block_length   = cur_blen;
      r.piece_valid    = cur_valid;
      r.piece_complete = cur_complete;
      return r;
   endfunction

   task automatic add_word(logic [7:0] b, logic start, logic last);
      stim_word_type w;
      w = '{b, start, last, '0, '0, '0, '0, '0, '0, '0};
      stim_words.push_back(w);
   endtask

   // queue one piece message, mostly well formed, sometimes broken
   task automatic queue_message();
      int          mode;
      int          hi;
      int          blen;
      int          data_n;
      int          extra;
      int          prefix;
      int          hdr_last;
      int          total;
      int          first_end;
      logic [31:0] len_field;
      logic [31:0] idx;
      logic [31:0] off;
      logic [7:0]  id;
      logic [7:0]  body [$];
      mode = $urandom_range(0, 19);
      hi   = (max_blen < 6) ? int'(max_blen) : 6;
      if ($urandom_range(0, 4) == 0) hi = (max_blen < 40) ? int'(max_blen) : 40;
      blen      = $urandom_range(0, hi);
      data_n    = blen;
      len_field = 32'(blen) + pmp_pkg::HDR_OVERHEAD;
      id        = pmp_pkg::PIECE_ID;
      idx       = $urandom;
      off       = $urandom;
      extra     = (mode == 6 || mode == 7) ? $urandom_range(1, 3) : $urandom_range(0, 2);
      if (mode == 0) prefix = 8;
      else prefix = ($urandom_range(0, 3) == 0) ? 4 : 0;
      case (mode)
         1: len_field = $urandom_range(1, 8);
         2: begin
            if ($urandom_range(0, 1) == 0)
               len_field = 32'(max_blen) + pmp_pkg::HDR_OVERHEAD + 32'd1 +
                           $urandom_range(0, 3);
            else
               len_field = $urandom | 32'h8000_0000;
         end
         3: begin
            do id = 8'($urandom_range(0, 255)); while (id == pmp_pkg::PIECE_ID);
         end
         10: begin
            len_field = 32'(max_blen) + pmp_pkg::HDR_OVERHEAD;
            data_n    = $urandom_range(0, 6);
         end
         default: ;
      endcase
      repeat (prefix) body.push_back(8'h00);
      for (int s = 24; s >= 0; s -= 8) body.push_back(len_field[s +: 8]);
      body.push_back(id);
      for (int s = 24; s >= 0; s -= 8) body.push_back(idx[s +: 8]);
      for (int s = 24; s >= 0; s -= 8) body.push_back(off[s +: 8]);
      repeat (data_n + extra) body.push_back(8'($urandom_range(0, 255)));
      hdr_last = prefix + 12;
      total    = body.size();
      if (mode == 4 || mode == 5)
         first_end = $urandom_range(0, hdr_last - 1);
      else if (mode == 6 || mode == 7)
         first_end = $urandom_range(hdr_last + data_n + 1, total - 1);
      else
         first_end = $urandom_range(hdr_last, hdr_last + data_n);
      if (mode == 8 || mode == 9) total = $urandom_range(1, total);
      for (int i = 0; i < total; i++)
         add_word(body[i], i == 0,
                  i == first_end || (i > first_end && $urandom_range(0, 3) == 0));
   endtask

   task automatic drive_words();
      stim_word_type       w;
      pmp_pkg::result_type r;
      int                  gap;
      while (stim_words.size() != 0) begin
         w = stim_words.pop_front();
         if ($urandom_range(0, 19) == 0) src_burst = !src_burst;
         gap = src_burst ? 0 : $urandom_range(0, 9);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_if.valid       <= 1'b1;
         req_if.data_byte   <= w.data_byte;
         req_if.new_piece   <= w.new_piece;
         req_if.payload_end <= w.payload_end;
         do @(posedge clock); while (!req_if.ready);
         r = classify_byte(w.data_byte, w.new_piece, w.payload_end);
         if (w.typed) begin
            r.byte_kind      = w.kind;
            r.piece_index    = w.index;
            r.block_offset   = w.offset;
            r.block_length   = w.blen;
            r.piece_valid    = w.valid;
            r.piece_complete = w.complete;
         end
         classified_due.push_back(r);
         words_in++;
         if (w.new_piece) pieces_opened++;
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (classified_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_blen(logic [15:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {pmp_pkg::CSR_IDX_MAX_LEN, 2'b00};
      csr_pwdata  <= {16'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // read back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== v) begin
         $display("%0t: max_block_length readback mismatch, expected %h, got %h",
                  $time, v, csr_prdata[15:0]);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      max_blen = v;
   endtask

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pmp_pkg::result_type want;
      if (rsp_if.valid && rsp_if.ready) begin
         words_out++;
         if (!$isunknown(rsp_if.byte_kind)) kind_count[rsp_if.byte_kind]++;
         if (classified_due.size() == 0) begin
            $display("%0t: unexpected classified byte, expected none, got %h",
                     $time, rsp_if.out_byte);
            fail_count++;
         end else begin
            want = classified_due.pop_front();
            check_field("out_byte", want.out_byte, rsp_if.out_byte);
            check_field("byte_kind", want.byte_kind, rsp_if.byte_kind);
            check_field("piece_index", want.piece_index, rsp_if.piece_index);
            check_field("block_offset", want.block_offset, rsp_if.block_offset);
            check_field("block_length", want.block_length, rsp_if.block_length);
            check_field("piece_valid", want.piece_valid, rsp_if.piece_valid);
            check_field("piece_complete", want.piece_complete, rsp_if.piece_complete);
         end
      end
   end

   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) sink_burst = !sink_burst;
         stall = sink_burst ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL piece_message_parser");
      $finish;
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.data_byte   = '0;
      req_if.new_piece   = 1'b0;
      req_if.payload_end = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      fail_count         = 0;
      words_in           = 0;
      words_out          = 0;
      pieces_opened      = 0;
      src_burst          = 1'b0;
      sink_burst         = 1'b0;
      foreach (kind_count[k]) kind_count[k] = 0;
      limit_plan = '{pmp_pkg::MAX_LEN_RESET, 16'd0, 16'hFFFF, 16'd20,
                     16'($urandom_range(1, 65534))};
      clear_parser();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_words[i]) stim_words.push_back(opening_words[i]);
      drive_words();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p != 0) begin
            wait_drained();
            write_max_blen(limit_plan[p]);
         end
         while (stim_words.size() < PHASE_WORDS) queue_message();
         drive_words();
      end

      wait_drained();
      $display("covered %0d bytes in, %0d out: header %0d, block %0d, leftover %0d, discard %0d",
               words_in, words_out, kind_count[pmp_pkg::KIND_HEADER],
               kind_count[pmp_pkg::KIND_BLOCK], kind_count[pmp_pkg::KIND_LEFTOVER],
               kind_count[pmp_pkg::KIND_DISCARD]);
      $display("%0d pieces opened under limits %0d, %0d, %0d, %0d, %0d", pieces_opened,
               limit_plan[0], limit_plan[1], limit_plan[2], limit_plan[3], limit_plan[4]);
      if (fail_count == 0 && classified_due.size() == 0)
         $display("PASS piece_message_parser");
      else
         $display("FAIL piece_message_parser");
      $finish;
   end

endmodule

// File: piece_message_parser.f
hdl/pmp_pkg.sv
hdl/pmp_req_if.sv
hdl/pmp_rsp_if.sv
hdl/pmp_front.sv
hdl/pmp_queue.sv
hdl/pmp_back.sv
hdl/piece_message_parser.sv
tb/piece_message_parser_test.sv
